// File: design/btpg_pkg.sv
// Shared types and constants for the blended trapezoid path generator.
// No dependencies; imported by every module of the block.
`default_nettype none
package btpg_pkg;

  localparam int MAX_TICKS = 4096;
  localparam int POS_BITS  = 32;
  localparam int TICK_W    = 13;
  localparam int DIV_NUM_W = 50;
  localparam int DIV_DEN_W = 14;
  localparam int DIV_CNT_W = 6;
  localparam int MUL_W     = 33;
  localparam int CORNER_W  = 48;
  localparam int X_W       = 50;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_REFUSED  = 2'd2,
    ST_IDLE     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ACCEL  = 2'd1,
    PH_CRUISE = 2'd2,
    PH_DECEL  = 2'd3
  } phase_e;

  typedef struct packed {
    phase_e              phase;
    logic [TICK_W-1:0]   len;
  } seg_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_NUM_W-1:0]  num;
    logic [DIV_DEN_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIV_NUM_W-1:0]  quo;
  } div_rsp_t;

endpackage
`default_nettype wire

// File: design/blended_trapezoid_path_generator.sv
// Blended trapezoid path generator: one-axis move planner and sampler.
// Uses btpg_pkg, btpg_div (serial divider) and btpg_mul (shared multiplier).
//
// Input stream: tuser selects the beat kind (0 start a move, 1 sample tick);
// tdata carries start and end position, total and blend ticks. Every input
// beat gives exactly one output beat: tdata is the position, tuser holds the
// sample-valid flag and the status, tlast marks the final sample of a move.
// The block takes one beat at a time and is not ready until its result has
// been handed to the output register.
// Work between the accepting edge and the output register load: none for a
// refused start or an idle tick; one multiply, then two 50-step divisions
// for an accepted start; one division and five multiplies for a blend
// sample; two multiplies for a cruise sample. The input is ready again once
// the output register is loaded, so a new beat is taken only after the
// previous one has reached the output register.
// The serial divider produces one quotient bit per cycle.
// Reset leaves the block idle with no move loaded. When the receiver stalls,
// the finished beat waits in the output register; the next holds at S_EMIT.
`default_nettype none
module blended_trapezoid_path_generator import btpg_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [95:0] s_axis_tdata,  // start_pos, end_pos, total_ticks, blend_ticks, pad
  input  wire         s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,  // position
  output logic [2:0]  m_axis_tuser,  // sample_valid, status
  output logic        m_axis_tlast
);

  typedef enum logic [17:0] {
    S_IDLE = 18'h00001, S_SMUL = 18'h00002, S_SDH = 18'h00004, S_SWH = 18'h00008,
    S_SDC  = 18'h00010, S_SWC  = 18'h00020, S_TWU = 18'h00040, S_TM2 = 18'h00080,
    S_TM3  = 18'h00100, S_TM4  = 18'h00200, S_TM5 = 18'h00400, S_TM6 = 18'h00800,
    S_TM7  = 18'h01000, S_CM1  = 18'h02000, S_CM2 = 18'h04000, S_CM3 = 18'h08000,
    S_SAT  = 18'h10000, S_EMIT = 18'h20000
  } state_e;

  function automatic seg_t enter_from(phase_e p, logic [TICK_W-1:0] bl,
                                      logic [TICK_W-1:0] cl);
    seg_t s;
    if (p <= PH_ACCEL && bl != '0) begin
      s.phase = PH_ACCEL;  s.len = bl;
    end else if (p <= PH_CRUISE && cl != '0) begin
      s.phase = PH_CRUISE; s.len = cl;
    end else if (bl != '0) begin
      s.phase = PH_DECEL;  s.len = bl;
    end else begin
      s.phase = PH_IDLE;   s.len = '0;
    end
    return s;
  endfunction

  state_e state_q, state_d;

  // move state
  phase_e              phase_q, phase_d;
  logic [TICK_W-1:0]   step_q, step_d, len_q, len_d;
  logic [TICK_W-1:0]   blend_q, blend_d, cruise_q, cruise_d;
  logic                neg_q, neg_d;
  logic [45:0]         hmag_q, hmag_d;
  logic [47:0]         cs_q, cs_d;
  logic signed [CORNER_W-1:0] x0_q, x0_d, xa_q, xa_d, xd_q, xd_d;

  // working registers
  logic signed [31:0]  in_x0_q, in_x0_d, in_xf_q, in_xf_d;
  logic [TICK_W-1:0]   tf_q, tf_d, ta_q, ta_d, td_q, td_d;
  logic [31:0]         dmag_q, dmag_d;
  logic                dneg_q, dneg_d;
  logic [MUL_W-1:0]    u_q, u_d, g_q, g_d;
  logic [63:0]         rnd_q, rnd_d;
  logic signed [X_W-1:0] x_q, x_d;
  logic [31:0]         res_pos_q, res_pos_d;
  logic                res_valid_q, res_valid_d, res_last_q, res_last_d;
  status_e             res_status_q, res_status_d;

  // output register
  logic                out_valid_q, out_valid_d;
  logic [31:0]         out_pos_q, out_pos_d;
  logic                out_sv_q, out_sv_d, out_last_q, out_last_d;
  status_e             out_status_q, out_status_d;

  div_req_t            div_req;
  div_rsp_t            div_rsp;
  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [2*MUL_W-1:0]  mul_p;

  btpg_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));
  btpg_mul u_mul (.clk_i, .a_i(mul_a), .b_i(mul_b), .p_o(mul_p));

  logic                 in_acc;
  logic signed [32:0]   d_in;
  logic [TICK_W-1:0]    tf_in, ta_in;
  logic [13:0]          two_ta;
  logic [TICK_W-1:0]    cl_new;
  logic signed [CORNER_W-1:0] h_s;
  logic [46:0]          span;
  logic [48:0]          r_mag;
  logic [63:0]          m_cr;
  logic [47:0]          off_cr;
  logic signed [X_W-1:0] base_x, off_x;
  logic signed [X_W-1:0] pos_max, pos_min;
  logic [TICK_W:0]      nstep;
  seg_t                 seg_n;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign tf_in  = s_axis_tdata[76:64];
  assign ta_in  = s_axis_tdata[89:77];
  assign d_in   = 33'(signed'(s_axis_tdata[63:32])) - 33'(signed'(s_axis_tdata[31:0]));
  assign pos_max = X_W'({(POS_BITS-1){1'b1}});
  assign pos_min = ~pos_max;

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;   step_d   = step_q;   len_d  = len_q;
    blend_d  = blend_q;   cruise_d = cruise_q; neg_d  = neg_q;
    hmag_d   = hmag_q;    cs_d     = cs_q;
    x0_d     = x0_q;      xa_d     = xa_q;     xd_d   = xd_q;
    in_x0_d  = in_x0_q;   in_xf_d  = in_xf_q;
    tf_d     = tf_q;      ta_d     = ta_q;     td_d   = td_q;
    dmag_d   = dmag_q;    dneg_d   = dneg_q;
    u_d      = u_q;       g_d      = g_q;      rnd_d  = rnd_q;  x_d = x_q;
    res_pos_d = res_pos_q; res_valid_d = res_valid_q;
    res_last_d = res_last_q; res_status_d = res_status_q;
    out_valid_d = out_valid_q; out_pos_d = out_pos_q; out_sv_d = out_sv_q;
    out_last_d = out_last_q; out_status_d = out_status_q;
    div_req = '0;
    mul_a = '0;
    mul_b = '0;
    two_ta = {1'b0, ta_q} << 1;
    cl_new = ({1'b0, tf_q} > two_ta) ? TICK_W'({1'b0, tf_q} - two_ta) : '0;
    h_s    = dneg_q ? -CORNER_W'(hmag_q) : CORNER_W'(hmag_q);
    span   = {1'b0, hmag_q} << 1;
    r_mag  = mul_p[48:0] + rnd_q[48:0];
    m_cr   = {mul_p[31:0], 32'b0} + rnd_q;
    off_cr = m_cr[63:16] + 48'((m_cr[15:0] + 17'h08000) >> 16);
    base_x = '0;
    off_x  = '0;
    nstep  = {1'b0, step_q} + 1'b1;
    seg_n  = '0;

    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_pos_d   = '0;
          res_valid_d = 1'b0;
          res_last_d  = 1'b0;
          if (!s_axis_tuser) begin
            if (tf_in == '0 || tf_in > TICK_W'(MAX_TICKS) || ta_in >= tf_in) begin
              res_status_d = ST_REFUSED;
              state_d = S_EMIT;
            end else begin
              in_x0_d = signed'(s_axis_tdata[31:0]);
              in_xf_d = signed'(s_axis_tdata[63:32]);
              tf_d    = tf_in;
              ta_d    = ta_in;
              td_d    = tf_in - ta_in;
              dneg_d  = d_in < 0;
              dmag_d  = d_in < 0 ? 32'(-d_in) : 32'(d_in);
              state_d = S_SMUL;
            end
          end else if (phase_q == PH_IDLE) begin
            res_status_d = ST_IDLE;
            state_d = S_EMIT;
          end else if (phase_q == PH_CRUISE) begin
            state_d = S_CM1;
          end else begin
            div_req.start = 1'b1;
            div_req.num   = {5'b0, step_q, 32'b0};
            div_req.den   = {1'b0, len_q};
            state_d = S_TWU;
          end
        end
      end
      S_SMUL: begin
        mul_a = {1'b0, dmag_q};
        mul_b = MUL_W'(ta_q);
        state_d = S_SDH;
      end
      S_SDH: begin
        div_req.start = 1'b1;
        div_req.num   = mul_p[DIV_NUM_W-1:0] + DIV_NUM_W'(td_q);
        div_req.den   = {td_q, 1'b0};
        state_d = S_SWH;
      end
      S_SWH: begin
        if (div_rsp.done) begin
          hmag_d  = div_rsp.quo[45:0];
          state_d = S_SDC;
        end
      end
      S_SDC: begin
        div_req.start = 1'b1;
        div_req.num   = {2'b0, dmag_q, 16'b0} + DIV_NUM_W'(td_q >> 1);
        div_req.den   = {1'b0, td_q};
        state_d = S_SWC;
      end
      S_SWC: begin
        if (div_rsp.done) begin
          cs_d     = div_rsp.quo[47:0];
          neg_d    = dneg_q;
          x0_d     = CORNER_W'(in_x0_q);
          xa_d     = CORNER_W'(in_x0_q) + h_s;
          xd_d     = CORNER_W'(in_xf_q) - h_s;
          blend_d  = ta_q;
          cruise_d = cl_new;
          seg_n    = enter_from(PH_ACCEL, ta_q, cl_new);
          phase_d  = seg_n.phase;
          len_d    = seg_n.len;
          step_d   = '0;
          res_status_d = ST_ACCEPTED;
          state_d  = S_EMIT;
        end
      end
      S_TWU: begin
        if (div_rsp.done) begin
          u_d   = div_rsp.quo[MUL_W-1:0];
          mul_a = div_rsp.quo[MUL_W-1:0];
          mul_b = div_rsp.quo[MUL_W-1:0];
          state_d = S_TM2;
        end
      end
      S_TM2: begin
        mul_a = {1'b0, mul_p[63:32]};
        mul_b = u_q;
        state_d = S_TM3;
      end
      S_TM3: begin
        mul_a = {1'b0, mul_p[63:32]};
        mul_b = {1'b1, 32'b0} - (u_q >> 1);
        state_d = S_TM4;
      end
      S_TM4: begin
        g_d = (phase_q == PH_ACCEL) ? {1'b0, mul_p[63:32]} : u_q - {1'b0, mul_p[63:32]};
        state_d = S_TM5;
      end
      S_TM5: begin
        mul_a = {1'b0, span[31:0]};
        mul_b = g_q;
        state_d = S_TM6;
      end
      S_TM6: begin
        rnd_d = 64'((mul_p[64:0] + 65'h080000000) >> 32);
        mul_a = MUL_W'(span[46:32]);
        mul_b = g_q;
        state_d = S_TM7;
      end
      S_TM7: begin
        base_x = (phase_q == PH_ACCEL) ? X_W'(x0_q) : X_W'(xd_q);
        off_x  = X_W'(r_mag);
        x_d    = neg_q ? base_x - off_x : base_x + off_x;
        state_d = S_SAT;
      end
      S_CM1: begin
        mul_a = {1'b0, cs_q[31:0]};
        mul_b = MUL_W'(step_q);
        state_d = S_CM2;
      end
      S_CM2: begin
        rnd_d = mul_p[63:0];
        mul_a = MUL_W'(cs_q[47:32]);
        mul_b = MUL_W'(step_q);
        state_d = S_CM3;
      end
      S_CM3: begin
        base_x = X_W'(xa_q);
        off_x  = X_W'(off_cr);
        x_d    = neg_q ? base_x - off_x : base_x + off_x;
        state_d = S_SAT;
      end
      S_SAT: begin
        if (x_q > pos_max)      res_pos_d = pos_max[31:0];
        else if (x_q < pos_min) res_pos_d = pos_min[31:0];
        else                    res_pos_d = x_q[31:0];
        res_valid_d  = 1'b1;
        res_status_d = ST_OK;
        res_last_d   = 1'b0;
        step_d = nstep[TICK_W-1:0];
        if (nstep >= {1'b0, len_q}) begin
          if (phase_q == PH_DECEL) seg_n = '{phase: PH_IDLE, len: '0};
          else seg_n = enter_from(phase_e'(phase_q + 2'd1), blend_q, cruise_q);
          phase_d = seg_n.phase;
          len_d   = seg_n.len;
          step_d  = '0;
          res_last_d = (seg_n.phase == PH_IDLE);
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_pos_d    = res_pos_q;
          out_sv_d     = res_valid_q;
          out_last_d   = res_last_q;
          out_status_d = res_status_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_IDLE;
      step_q      <= '0;
      len_q       <= '0;
      blend_q     <= '0;
      cruise_q    <= '0;
      cs_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      step_q      <= step_d;
      len_q       <= len_d;
      blend_q     <= blend_d;
      cruise_q    <= cruise_d;
      cs_q        <= cs_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;     hmag_q <= hmag_d;
    x0_q <= x0_d;       xa_q <= xa_d;       xd_q <= xd_d;
    in_x0_q <= in_x0_d; in_xf_q <= in_xf_d;
    tf_q <= tf_d;       ta_q <= ta_d;       td_q <= td_d;
    dmag_q <= dmag_d;   dneg_q <= dneg_d;
    u_q <= u_d;         g_q <= g_d;         rnd_q <= rnd_d;  x_q <= x_d;
    res_pos_q <= res_pos_d;   res_valid_q <= res_valid_d;
    res_last_q <= res_last_d; res_status_q <= res_status_d;
    out_pos_q <= out_pos_d;   out_sv_q <= out_sv_d;
    out_last_q <= out_last_d; out_status_q <= out_status_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pos_q;
  assign m_axis_tuser  = {out_status_q, out_sv_q};
  assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire

// File: design/btpg_div.sv
// Bit-serial restoring divider, one quotient bit per clock.
// Depends on btpg_pkg for widths and request/response structs.
`default_nettype none
module btpg_div import btpg_pkg::*; (
  input  wire      clk_i,
  input  wire      rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIV_DEN_W-1:0]  rem_q, rem_d;
  logic [DIV_DEN_W-1:0]  den_q, den_d;
  logic [DIV_NUM_W-1:0]  quo_q, quo_d;
  logic [DIV_DEN_W:0]    rem_sh;
  logic [DIV_DEN_W:0]    rem_sub;
  logic                  ge;

  always_comb begin
    rem_sh  = {rem_q, quo_q[DIV_NUM_W-1]};
    ge      = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    den_d   = den_q;
    quo_d   = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      den_d  = req_i.den;
      quo_d  = req_i.num;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
      quo_d = {quo_q[DIV_NUM_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule
`default_nettype wire

// File: design/btpg_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on btpg_pkg for the operand width.
`default_nettype none
module btpg_mul import btpg_pkg::*; (
  input  wire              clk_i,
  input  wire  [MUL_W-1:0] a_i,
  input  wire  [MUL_W-1:0] b_i,
  output logic [2*MUL_W-1:0] p_o
);

  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end

endmodule
`default_nettype wire
